@@ design/name_rule_cpu_steering_table_top_defines.svh @@
// Assertion macros used by the checker of this block.
`ifndef NAME_RULE_CPU_STEERING_TABLE_TOP_DEFINES_SVH
`define NAME_RULE_CPU_STEERING_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NRCST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define NRCST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ design/nrcst_pkg.sv @@
`timescale 1ns / 1ps
package nrcst_pkg;

   typedef enum logic [1:0] {
      FUNC_STEER = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RESOLVE
   } state_type;

   localparam logic [7:0] ACT_LITTLE  = 8'd1;
   localparam logic [7:0] ACT_SEVEN   = 8'd2;
   localparam logic [7:0] ACT_MIDDLE  = 8'd3;
   localparam logic [7:0] CPU_MAX     = 8'd7;
   localparam logic [7:0] CPU_SEVEN   = 8'd7;
   localparam logic [7:0] MIDDLE_BASE = 8'd4;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 16;
   localparam int RAW_BYTES  = 16;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic eval;
      logic write;
      logic clear;
      logic steer_ok;
      logic eq_any;
   } ctrl_type;

   // Priority information handed from one cell to the next.
   typedef struct packed {
      logic       hit_seen;
      logic [7:0] hit_kind;
      logic       eq_seen;
      logic       free_seen;
   } link_type;

   function automatic logic [7:0] mod3(input logic [2:0] v);
      logic [7:0] r;
      case (v)
         3'd0: r = 8'd0;
         3'd1: r = 8'd1;
         3'd2: r = 8'd2;
         3'd3: r = 8'd0;
         3'd4: r = 8'd1;
         3'd5: r = 8'd2;
         3'd6: r = 8'd0;
         3'd7: r = 8'd1;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

@@ design/nrcst_cell.sv @@
`timescale 1ns / 1ps
module nrcst_cell #(
   parameter int NAME_BYTES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  nrcst_pkg::ctrl_type       ctrl,
   input  logic [NAME_BYTES*8-1:0]   item_name,
   input  logic [7:0]                item_action,
   input  nrcst_pkg::link_type       link_prev,
   output nrcst_pkg::link_type       link_next
);

   logic                    valid_ff, valid_in;
   logic [NAME_BYTES*8-1:0] name_ff, name_in;
   logic [7:0]              kind_ff, kind_in;
   logic                    hit_ff, hit_in;
   logic                    eq_ff, eq_in;
   logic                    free_ff, free_in;
   logic                    found;
   logic                    wr_sel;

   always_comb begin
      logic all_ok;
      logic [7:0] nb;
      found = 1'b0;
      for (int s = 0; s < NAME_BYTES; s++) begin
         all_ok = 1'b1;
         for (int k = 0; k < NAME_BYTES; k++) begin
            nb = name_ff[8*k +: 8];
            if (nb != 8'd0) begin
               if (s + k < NAME_BYTES) begin
                  if (item_name[8*((s + k) % NAME_BYTES) +: 8] != nb) begin
                     all_ok = 1'b0;
                  end
               end else begin
                  all_ok = 1'b0;
               end
            end
         end
         found = found | all_ok;
      end
   end

   assign wr_sel = ctrl.write &&
      (ctrl.eq_any ? (eq_ff && !link_prev.eq_seen) : (free_ff && !link_prev.free_seen));

   always_comb begin
      hit_in   = hit_ff;
      eq_in    = eq_ff;
      free_in  = free_ff;
      valid_in = valid_ff;
      name_in  = name_ff;
      kind_in  = kind_ff;
      if (ctrl.eval) begin
         hit_in  = valid_ff && ctrl.steer_ok && (name_ff[7:0] != 8'd0) && found;
         eq_in   = valid_ff && (name_ff == item_name);
         free_in = !valid_ff;
      end
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (wr_sel) begin
         valid_in = 1'b1;
         name_in  = item_name;
         kind_in  = item_action;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff <= name_in;
      kind_ff <= kind_in;
      hit_ff  <= hit_in;
      eq_ff   <= eq_in;
      free_ff <= free_in;
   end

   always_comb begin
      link_next.hit_seen  = link_prev.hit_seen | hit_ff;
      link_next.hit_kind  = (!link_prev.hit_seen && hit_ff) ? kind_ff : link_prev.hit_kind;
      link_next.eq_seen   = link_prev.eq_seen | eq_ff;
      link_next.free_seen = link_prev.free_seen | free_ff;
   end

endmodule

@@ design/name_rule_cpu_steering_table_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  tdata                                        tuser
// req_      in         name_low, name_high, proposed_cpu,           func
//                      rule_action (144 bits)
// rsp_      out        steered_cpu, rule_matched, status (16 bits)  none
//
// The result is registered after an evaluate state, in which every rule cell compares the item
// with its rule, and a resolve state, in which the priority chain through the cells picks the
// rule and updates the table.
// Reset clears every rule at once; no sweep is needed.
// A result that is not taken stalls the resolve cycle; a new item is accepted as soon as the
// previous one has moved into the output register, so items are never overlapped.
module name_rule_cpu_steering_table_top #(
   parameter int RULE_COUNT = 16,
   parameter int NAME_BYTES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // name_low[63:0], name_high[127:64], proposed_cpu[135:128], rule_action[143:136]
   input  logic [nrcst_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // steered_cpu[7:0], rule_matched[8], status[9], zero[15:10]
   output logic [nrcst_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int NAME_W = NAME_BYTES * 8;

   nrcst_pkg::state_type       state_ff, state_in;
   nrcst_pkg::func_type        func_ff, func_in;
   logic [NAME_W-1:0]          name_ff, name_in;
   logic [7:0]                 cpu_ff, cpu_in;
   logic [7:0]                 act_ff, act_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [nrcst_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [7:0]                 raw_byte [NAME_BYTES];
   logic [NAME_W-1:0]          norm_name;
   logic                       accept;
   logic                       advance;
   logic [7:0]                 steer_cpu;
   nrcst_pkg::ctrl_type        ctrl;
   nrcst_pkg::link_type        link [RULE_COUNT+1];

   for (genvar gi = 0; gi < NAME_BYTES; gi++) begin : g_raw
      if (gi < NAME_BYTES - 1 && gi < nrcst_pkg::RAW_BYTES) begin : g_used
         assign raw_byte[gi] = req_tdata[8*gi +: 8];
      end else begin : g_zero
         assign raw_byte[gi] = 8'd0;
      end
   end

   always_comb begin
      logic seen_zero;
      seen_zero = 1'b0;
      norm_name = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (raw_byte[i] == 8'd0) begin
            seen_zero = 1'b1;
         end
         norm_name[8*i +: 8] = seen_zero ? 8'd0 : raw_byte[i];
      end
   end

   assign req_tready = (state_ff == nrcst_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign advance    = (state_ff == nrcst_pkg::ST_RESOLVE) && (!rsp_valid_ff || rsp_tready);

   assign link[0] = '0;

   always_comb begin
      ctrl.eval     = (state_ff == nrcst_pkg::ST_EVAL);
      ctrl.write    = advance && (func_ff == nrcst_pkg::FUNC_SET);
      ctrl.clear    = advance && (func_ff == nrcst_pkg::FUNC_CLEAR);
      ctrl.steer_ok = (cpu_ff <= nrcst_pkg::CPU_MAX) && (name_ff[7:0] != 8'd0);
      ctrl.eq_any   = link[RULE_COUNT].eq_seen;
   end

   for (genvar gc = 0; gc < RULE_COUNT; gc++) begin : g_cell
      nrcst_cell #(
         .NAME_BYTES(NAME_BYTES)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .item_name  (name_ff),
         .item_action(act_ff),
         .link_prev  (link[gc]),
         .link_next  (link[gc+1])
      );
   end

   always_comb begin
      case (link[RULE_COUNT].hit_kind)
         nrcst_pkg::ACT_LITTLE: steer_cpu = nrcst_pkg::mod3(cpu_ff[2:0]);
         nrcst_pkg::ACT_SEVEN:  steer_cpu = nrcst_pkg::CPU_SEVEN;
         nrcst_pkg::ACT_MIDDLE: steer_cpu = nrcst_pkg::MIDDLE_BASE
                                            + nrcst_pkg::mod3(cpu_ff[2:0]);
         default:               steer_cpu = cpu_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      name_in      = name_ff;
      cpu_in       = cpu_ff;
      act_in       = act_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         nrcst_pkg::ST_IDLE: begin
            if (accept) begin
               func_in  = nrcst_pkg::func_type'(req_tuser);
               name_in  = norm_name;
               cpu_in   = req_tdata[135:128];
               act_in   = req_tdata[143:136];
               state_in = nrcst_pkg::ST_EVAL;
            end
         end
         nrcst_pkg::ST_EVAL: begin
            state_in = nrcst_pkg::ST_RESOLVE;
         end
         nrcst_pkg::ST_RESOLVE: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               case (func_ff)
                  nrcst_pkg::FUNC_STEER: begin
                     rsp_data_in[8]   = link[RULE_COUNT].hit_seen;
                     rsp_data_in[7:0] = link[RULE_COUNT].hit_seen ? steer_cpu : cpu_ff;
                  end
                  nrcst_pkg::FUNC_SET: begin
                     rsp_data_in[9] = !link[RULE_COUNT].eq_seen
                                      && !link[RULE_COUNT].free_seen;
                  end
                  default: begin
                     rsp_data_in = '0;
                  end
               endcase
               state_in = nrcst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nrcst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nrcst_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      name_ff     <= name_in;
      cpu_ff      <= cpu_in;
      act_ff      <= act_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ design/nrcst_checker.sv @@
`timescale 1ns / 1ps
`include "name_rule_cpu_steering_table_top_defines.svh"
module nrcst_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [nrcst_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   `NRCST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `NRCST_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   `NRCST_ASSERT_NOW(a_match_or_full, clock, reset, rsp_tvalid, !(rsp_tdata[8] && rsp_tdata[9]))
   `NRCST_ASSERT_NOW(a_full_cpu_zero, clock, reset, rsp_tvalid && rsp_tdata[9], rsp_tdata[7:0] == 8'd0)
   `NRCST_ASSERT_NOW(a_match_cpu_range, clock, reset, rsp_tvalid && rsp_tdata[8], rsp_tdata[7:3] == 5'd0)

endmodule

bind name_rule_cpu_steering_table_top nrcst_checker u_nrcst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
